// File: rtl/bfpa_pkg.sv
// Shared types, sizes and codes of the best-fit pool allocator.
`timescale 1ns / 1ps
package bfpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int FREE_N    = 64;
    localparam int USED_N    = 64;
    localparam int FIDX_W    = $clog2(FREE_N);
    localparam int UIDX_W    = $clog2(USED_N);
    localparam int FCNT_W    = $clog2(FREE_N + 1);
    localparam int ALIGN_W   = 4;
    localparam int RALIGN_W  = 13;
    localparam int BASE_W    = 2 ** ALIGN_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(4);
    localparam logic [ADDR_W-1:0]  POOL_RESET  = '1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN     = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_NOT_ALLOC  = 3'd2,
        ST_BAD_ALIGN  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_ALIGN,
        S_A_SRD,
        S_A_SCHK,
        S_A_DECIDE,
        S_A_URD,
        S_A_UCHK,
        S_A_SUB,
        S_A_TRIM,
        S_F_URD,
        S_F_UCHK,
        S_F_END,
        S_F_SRD,
        S_F_SCHK,
        S_FA1,
        S_FA2,
        S_FA3,
        S_FA4,
        S_FB1,
        S_FB2,
        S_FB3,
        S_FB4,
        S_FI_RD,
        S_FI_WR,
        S_RM_RD,
        S_RM_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                command;
        logic [ADDR_W-1:0]   request_size;
        logic [RALIGN_W-1:0] request_alignment;
        logic [ADDR_W-1:0]   address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
        logic [ADDR_W-1:0] largest_free;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pool_bytes;
        logic [ALIGN_W-1:0] align_log2;
        logic               init;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [FIDX_W-1:0] addr;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
    } fwr_t;

    typedef struct packed {
        logic              we;
        logic [UIDX_W-1:0] addr;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
    } uwr_t;

endpackage

// File: rtl/bfpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/bfpa_alu.sv
// Shared add/subtract unit of the allocator sequencer.
`timescale 1ns / 1ps
module bfpa_alu (
    input  logic [bfpa_pkg::ADDR_W:0] a,
    input  logic [bfpa_pkg::ADDR_W:0] b,
    input  logic                      sub,
    output logic [bfpa_pkg::ADDR_W:0] y
);
    import bfpa_pkg::*;

    always_comb
    begin
        if (sub)
        begin
            y = a - b;
        end
        else
        begin
            y = a + b;
        end
    end

endmodule

// File: rtl/bfpa_ctrl.sv
// Sequencer and datapath registers of the allocator: table scans, merges, shifts.
`timescale 1ns / 1ps
module bfpa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bfpa_pkg::req_t                req,
    input  bfpa_pkg::cfg_t                cfg,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bfpa_pkg::rsp_t                res,
    output bfpa_pkg::fwr_t                f_wr,
    output logic [bfpa_pkg::FIDX_W-1:0]   f_raddr,
    input  logic [bfpa_pkg::ADDR_W-1:0]   f_rstart,
    input  logic [bfpa_pkg::ADDR_W-1:0]   f_rlen,
    output bfpa_pkg::uwr_t                u_wr,
    output logic [bfpa_pkg::UIDX_W-1:0]   u_raddr,
    input  logic [bfpa_pkg::ADDR_W-1:0]   u_rstart,
    input  logic [bfpa_pkg::ADDR_W-1:0]   u_rlen
);
    import bfpa_pkg::*;

    state_t              state_reg, state_next;
    logic [FCNT_W-1:0]   free_count_reg, free_count_next;
    logic                e0_init_reg, e0_init_next;
    logic                f_rd0_reg, f_rd0_next;
    logic [USED_N-1:0]   used_valid_reg, used_valid_next;

    logic [ADDR_W:0]     size_reg, size_next;
    logic [RALIGN_W-1:0] ralign_reg, ralign_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]   largest_reg, largest_next;
    logic                found_reg, found_next;
    logic [FIDX_W-1:0]   best_reg, best_next;
    logic [ADDR_W-1:0]   best_len_reg, best_len_next;
    logic [ADDR_W-1:0]   best_start_reg, best_start_next;
    logic                have_free_reg, have_free_next;
    logic [UIDX_W-1:0]   free_slot_reg, free_slot_next;
    logic [UIDX_W-1:0]   slot_reg, slot_next;
    logic [UIDX_W-1:0]   rec_reg, rec_next;
    logic [ADDR_W-1:0]   bs_reg, bs_next;
    logic [ADDR_W-1:0]   bl_reg, bl_next;
    logic [ADDR_W-1:0]   cur_start_reg, cur_start_next;
    logic [ADDR_W-1:0]   cur_len_reg, cur_len_next;
    logic [ADDR_W-1:0]   aux_len_reg, aux_len_next;
    logic [ADDR_W:0]     end_reg, end_next;
    logic [FCNT_W-1:0]   pos_reg, pos_next;
    logic [FCNT_W-1:0]   fidx_reg, fidx_next;
    logic [UIDX_W-1:0]   uidx_reg, uidx_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_largest_reg, res_largest_next;

    logic [ADDR_W:0]     alu_a, alu_b, alu_y;
    logic                alu_sub;

    logic [ADDR_W-1:0]   eff_start, eff_len;
    logic [FCNT_W-1:0]   fidx_p1, fidx_m1;
    logic                more_f, count_full, u_last, u_hit, have_free_any;
    logic [ADDR_W-1:0]   u_key;
    logic [BASE_W-1:0]   base, base_m1;
    logic                bad_align;
    logic                y_eq_ptr, y_eq_start, end_eq_bs;
    logic                accept;

    bfpa_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    assign eff_start  = (f_rd0_reg && e0_init_reg) ? '0 : f_rstart;
    assign eff_len    = (f_rd0_reg && e0_init_reg) ? cfg.pool_bytes : f_rlen;
    assign fidx_p1    = fidx_reg + FCNT_W'(1);
    assign fidx_m1    = fidx_reg - FCNT_W'(1);
    assign more_f     = fidx_p1 < free_count_reg;
    assign count_full = free_count_reg >= FCNT_W'(FREE_N);
    assign u_last     = uidx_reg == UIDX_W'(USED_N - 1);
    assign u_key      = (state_reg == S_A_UCHK) ? best_start_reg : ptr_reg;
    assign u_hit      = used_valid_reg[uidx_reg] && (u_rstart == u_key);
    assign have_free_any = have_free_reg || !used_valid_reg[uidx_reg];
    assign base       = BASE_W'(1) << cfg.align_log2;
    assign base_m1    = base - BASE_W'(1);
    assign bad_align  = ((ralign_reg & (ralign_reg - RALIGN_W'(1))) != '0) ||
                        ({{(BASE_W - RALIGN_W){1'b0}}, ralign_reg} > base);
    assign y_eq_ptr   = alu_y == {1'b0, ptr_reg};
    assign y_eq_start = alu_y == {1'b0, eff_start};
    assign end_eq_bs  = end_reg == {1'b0, eff_start};
    assign accept     = req_valid && !req_stall;

    assign req_stall = state_reg != S_IDLE;
    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res.block_address = res_addr_reg;
    assign res.status        = res_status_reg;
    assign res.largest_free  = res_largest_reg;
    assign u_raddr = uidx_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.command == CMD_ALLOC) ? S_A_ALIGN : S_F_URD;
                end
            end
            S_A_ALIGN:
            begin
                if (bad_align)
                begin
                    state_next = S_DONE;
                end
                else if (free_count_reg == '0)
                begin
                    state_next = S_A_DECIDE;
                end
                else
                begin
                    state_next = S_A_SRD;
                end
            end
            S_A_SRD:    state_next = S_A_SCHK;
            S_A_SCHK:   state_next = more_f ? S_A_SRD : S_A_DECIDE;
            S_A_DECIDE: state_next = (!found_reg || size_reg[ADDR_W]) ? S_DONE : S_A_URD;
            S_A_URD:    state_next = S_A_UCHK;
            S_A_UCHK:
            begin
                if (u_hit)
                begin
                    state_next = S_A_SUB;
                end
                else if (u_last)
                begin
                    state_next = have_free_any ? S_A_SUB : S_DONE;
                end
                else
                begin
                    state_next = S_A_URD;
                end
            end
            S_A_SUB:    state_next = ({1'b0, best_len_reg} > size_reg) ? S_A_TRIM : S_RM_RD;
            S_A_TRIM:   state_next = S_DONE;
            S_F_URD:    state_next = S_F_UCHK;
            S_F_UCHK:
            begin
                if (u_hit)
                begin
                    state_next = S_F_END;
                end
                else if (u_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F_URD;
                end
            end
            S_F_END:    state_next = (free_count_reg == '0) ? S_FI_RD : S_F_SRD;
            S_F_SRD:    state_next = S_F_SCHK;
            S_F_SCHK:
            begin
                if (y_eq_ptr)
                begin
                    state_next = S_FA1;
                end
                else if (end_eq_bs)
                begin
                    state_next = S_FB1;
                end
                else if (more_f)
                begin
                    state_next = S_F_SRD;
                end
                else
                begin
                    state_next = count_full ? S_DONE : S_FI_RD;
                end
            end
            S_FA1:      state_next = S_FA2;
            S_FA2:      state_next = more_f ? S_FA3 : S_DONE;
            S_FA3:      state_next = y_eq_start ? S_FA4 : S_DONE;
            S_FA4:      state_next = S_RM_RD;
            S_FB1:      state_next = S_FB2;
            S_FB2:      state_next = (fidx_reg != '0) ? S_FB3 : S_DONE;
            S_FB3:      state_next = y_eq_ptr ? S_FB4 : S_DONE;
            S_FB4:      state_next = S_RM_RD;
            S_FI_RD:    state_next = (fidx_reg > pos_reg) ? S_FI_WR : S_DONE;
            S_FI_WR:    state_next = S_FI_RD;
            S_RM_RD:    state_next = more_f ? S_RM_WR : S_DONE;
            S_RM_WR:    state_next = S_RM_RD;
            S_DONE:     state_next = res_ready ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_A_ALIGN:
            begin
                alu_a = size_reg;
                alu_b = (ADDR_W + 1)'(base_m1);
            end
            S_A_SUB:
            begin
                alu_a   = {1'b0, best_len_reg};
                alu_b   = size_reg;
                alu_sub = 1'b1;
            end
            S_A_TRIM:
            begin
                alu_a = {1'b0, best_start_reg};
                alu_b = size_reg;
            end
            S_F_END:
            begin
                alu_a = {1'b0, ptr_reg};
                alu_b = size_reg;
            end
            S_F_SCHK, S_FB3:
            begin
                alu_a = {1'b0, eff_start};
                alu_b = {1'b0, eff_len};
            end
            S_FA1, S_FB1:
            begin
                alu_a = {1'b0, bl_reg};
                alu_b = size_reg;
            end
            S_FA3:
            begin
                alu_a = {1'b0, cur_start_reg};
                alu_b = {1'b0, cur_len_reg};
            end
            S_FA4, S_FB4:
            begin
                alu_a = {1'b0, cur_len_reg};
                alu_b = {1'b0, aux_len_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        free_count_next  = free_count_reg;
        e0_init_next     = e0_init_reg;
        used_valid_next  = used_valid_reg;
        size_next        = size_reg;
        ralign_next      = ralign_reg;
        ptr_next         = ptr_reg;
        largest_next     = largest_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        best_len_next    = best_len_reg;
        best_start_next  = best_start_reg;
        have_free_next   = have_free_reg;
        free_slot_next   = free_slot_reg;
        slot_next        = slot_reg;
        rec_next         = rec_reg;
        bs_next          = bs_reg;
        bl_next          = bl_reg;
        cur_start_next   = cur_start_reg;
        cur_len_next     = cur_len_reg;
        aux_len_next     = aux_len_reg;
        end_next         = end_reg;
        pos_next         = pos_reg;
        fidx_next        = fidx_reg;
        uidx_next        = uidx_reg;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        res_largest_next = res_largest_reg;
        f_wr             = '0;
        u_wr             = '0;
        f_raddr          = fidx_reg[FIDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next        = {1'b0, req.request_size};
                    ralign_next      = req.request_alignment;
                    ptr_next         = req.address;
                    largest_next     = '0;
                    found_next       = 1'b0;
                    have_free_next   = 1'b0;
                    fidx_next        = '0;
                    uidx_next        = '0;
                    res_addr_next    = '0;
                    res_largest_next = '0;
                    res_status_next  = ST_OK;
                end
            end
            S_A_ALIGN:
            begin
                if (bad_align)
                begin
                    res_status_next = ST_BAD_ALIGN;
                end
                else
                begin
                    size_next = alu_y & ~((ADDR_W + 1)'(base_m1));
                end
            end
            S_A_SCHK:
            begin
                if (eff_len > largest_reg)
                begin
                    largest_next = eff_len;
                end
                if (({1'b0, eff_len} >= size_reg) && (!found_reg || eff_len <= best_len_reg))
                begin
                    found_next      = 1'b1;
                    best_next       = fidx_reg[FIDX_W-1:0];
                    best_len_next   = eff_len;
                    best_start_next = eff_start;
                end
                if (more_f)
                begin
                    fidx_next = fidx_p1;
                end
            end
            S_A_DECIDE:
            begin
                res_largest_next = largest_reg;
                if (!found_reg || size_reg[ADDR_W])
                begin
                    res_status_next = ST_NO_SPACE;
                end
            end
            S_A_UCHK:
            begin
                if (u_hit)
                begin
                    slot_next = uidx_reg;
                end
                else
                begin
                    if (!used_valid_reg[uidx_reg] && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_slot_next = uidx_reg;
                    end
                    if (u_last)
                    begin
                        if (have_free_any)
                        begin
                            slot_next = have_free_reg ? free_slot_reg : uidx_reg;
                        end
                        else
                        begin
                            res_status_next = ST_TABLE_FULL;
                        end
                    end
                    else
                    begin
                        uidx_next = uidx_reg + UIDX_W'(1);
                    end
                end
            end
            S_A_SUB:
            begin
                u_wr.we    = 1'b1;
                u_wr.addr  = slot_reg;
                u_wr.start = best_start_reg;
                u_wr.len   = size_reg[ADDR_W-1:0];
                used_valid_next[slot_reg] = 1'b1;
                res_addr_next = best_start_reg;
                cur_len_next  = alu_y[ADDR_W-1:0];
                fidx_next     = FCNT_W'(best_reg);
            end
            S_A_TRIM:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = best_reg;
                f_wr.start = alu_y[ADDR_W-1:0];
                f_wr.len   = cur_len_reg;
            end
            S_F_UCHK:
            begin
                if (u_hit)
                begin
                    rec_next  = uidx_reg;
                    size_next = {1'b0, u_rlen};
                end
                else if (u_last)
                begin
                    res_status_next = ST_NOT_ALLOC;
                end
                else
                begin
                    uidx_next = uidx_reg + UIDX_W'(1);
                end
            end
            S_F_END:
            begin
                end_next  = alu_y;
                fidx_next = '0;
                pos_next  = free_count_reg;
            end
            S_F_SCHK:
            begin
                bs_next = eff_start;
                bl_next = eff_len;
                if ((pos_reg == free_count_reg) && (eff_start >= ptr_reg))
                begin
                    pos_next = fidx_reg;
                end
                if (!y_eq_ptr && !end_eq_bs)
                begin
                    if (more_f)
                    begin
                        fidx_next = fidx_p1;
                    end
                    else if (count_full)
                    begin
                        res_status_next = ST_TABLE_FULL;
                    end
                    else
                    begin
                        fidx_next = free_count_reg;
                    end
                end
            end
            S_FA1:
            begin
                cur_start_next = bs_reg;
                cur_len_next   = alu_y[ADDR_W-1:0];
                used_valid_next[rec_reg] = 1'b0;
            end
            S_FA2:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = fidx_reg[FIDX_W-1:0];
                f_wr.start = cur_start_reg;
                f_wr.len   = cur_len_reg;
                f_raddr    = fidx_p1[FIDX_W-1:0];
            end
            S_FA3:
            begin
                aux_len_next = eff_len;
            end
            S_FA4:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = fidx_reg[FIDX_W-1:0];
                f_wr.start = cur_start_reg;
                f_wr.len   = alu_y[ADDR_W-1:0];
                fidx_next  = fidx_p1;
            end
            S_FB1:
            begin
                cur_start_next = ptr_reg;
                cur_len_next   = alu_y[ADDR_W-1:0];
                used_valid_next[rec_reg] = 1'b0;
            end
            S_FB2:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = fidx_reg[FIDX_W-1:0];
                f_wr.start = ptr_reg;
                f_wr.len   = cur_len_reg;
                f_raddr    = fidx_m1[FIDX_W-1:0];
            end
            S_FB3:
            begin
                bs_next      = eff_start;
                aux_len_next = eff_len;
            end
            S_FB4:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = fidx_m1[FIDX_W-1:0];
                f_wr.start = bs_reg;
                f_wr.len   = alu_y[ADDR_W-1:0];
            end
            S_FI_RD:
            begin
                f_raddr = fidx_m1[FIDX_W-1:0];
                if (fidx_reg == pos_reg)
                begin
                    f_wr.we    = 1'b1;
                    f_wr.addr  = pos_reg[FIDX_W-1:0];
                    f_wr.start = ptr_reg;
                    f_wr.len   = size_reg[ADDR_W-1:0];
                    free_count_next = free_count_reg + FCNT_W'(1);
                    used_valid_next[rec_reg] = 1'b0;
                end
            end
            S_FI_WR:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = fidx_reg[FIDX_W-1:0];
                f_wr.start = eff_start;
                f_wr.len   = eff_len;
                fidx_next  = fidx_m1;
            end
            S_RM_RD:
            begin
                f_raddr = fidx_p1[FIDX_W-1:0];
                if (!more_f)
                begin
                    free_count_next = free_count_reg - FCNT_W'(1);
                end
            end
            S_RM_WR:
            begin
                f_wr.we    = 1'b1;
                f_wr.addr  = fidx_reg[FIDX_W-1:0];
                f_wr.start = eff_start;
                f_wr.len   = eff_len;
                fidx_next  = fidx_p1;
            end
            default:
            begin
                f_raddr = fidx_reg[FIDX_W-1:0];
            end
        endcase

        if (f_wr.we && (f_wr.addr == '0))
        begin
            e0_init_next = 1'b0;
        end
        if (cfg.init)
        begin
            free_count_next = FCNT_W'(1);
            e0_init_next    = 1'b1;
            used_valid_next = '0;
        end
    end

    assign f_rd0_next = f_raddr == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= FCNT_W'(1);
            e0_init_reg    <= 1'b1;
            f_rd0_reg      <= 1'b0;
            used_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            e0_init_reg    <= e0_init_next;
            f_rd0_reg      <= f_rd0_next;
            used_valid_reg <= used_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        ralign_reg      <= ralign_next;
        ptr_reg         <= ptr_next;
        largest_reg     <= largest_next;
        found_reg       <= found_next;
        best_reg        <= best_next;
        best_len_reg    <= best_len_next;
        best_start_reg  <= best_start_next;
        have_free_reg   <= have_free_next;
        free_slot_reg   <= free_slot_next;
        slot_reg        <= slot_next;
        rec_reg         <= rec_next;
        bs_reg          <= bs_next;
        bl_reg          <= bl_next;
        cur_start_reg   <= cur_start_next;
        cur_len_reg     <= cur_len_next;
        aux_len_reg     <= aux_len_next;
        end_reg         <= end_next;
        pos_reg         <= pos_next;
        fidx_reg        <= fidx_next;
        uidx_reg        <= uidx_next;
        res_addr_reg    <= res_addr_next;
        res_status_reg  <= res_status_next;
        res_largest_reg <= res_largest_next;
    end

endmodule

// File: rtl/best_fit_pool_allocator.sv
// Sequence, accept to result beat: allocate scans the free blocks, then the records, then
//   writes the record and trims the best block or removes it, moving later entries down;
//   bad alignment skips the scans; free scans records, then blocks, then merges or inserts.
// Throughput: one command at a time; each table visit is a registered read, then a check.
// Reset: pool is one free block [0, pool bytes), no records valid; no clearing pass.
`timescale 1ns / 1ps
module best_fit_pool_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  bfpa_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output bfpa_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]      cfg_data
);
    import bfpa_pkg::*;

    logic [ADDR_W-1:0]  pool_bytes_reg, pool_bytes_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg;
    cfg_t               cfg;
    logic               idle, res_valid, res_ready, cfg_beat;
    rsp_t               res;
    fwr_t               f_wr;
    uwr_t               u_wr;
    logic [FIDX_W-1:0]  f_raddr;
    logic [UIDX_W-1:0]  u_raddr;
    logic [ADDR_W-1:0]  f_rstart, f_rlen, u_rstart, u_rlen;

    assign cfg_ready = idle;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cfg.pool_bytes = pool_bytes_reg;
    assign cfg.align_log2 = align_reg;
    assign cfg.init       = cfg_beat && (cfg_index == CFG_POOL_SIZE);

    always_comb
    begin
        pool_bytes_next = pool_bytes_reg;
        align_next      = align_reg;
        if (cfg_beat)
        begin
            unique case (cfg_index)
                CFG_POOL_SIZE: pool_bytes_next = cfg_data;
                CFG_ALIGN:     align_next      = cfg_data[ALIGN_W-1:0];
                default:       align_next      = align_reg;
            endcase
        end
        rsp_valid_next = (res_valid && res_ready) || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_bytes_reg <= POOL_RESET;
            align_reg      <= ALIGN_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            pool_bytes_reg <= pool_bytes_next;
            align_reg      <= align_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    bfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg       (cfg),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .f_wr      (f_wr),
        .f_raddr   (f_raddr),
        .f_rstart  (f_rstart),
        .f_rlen    (f_rlen),
        .u_wr      (u_wr),
        .u_raddr   (u_raddr),
        .u_rstart  (u_rstart),
        .u_rlen    (u_rlen)
    );

    bfpa_ram #(.WIDTH(ADDR_W), .DEPTH(FREE_N)) u_free_start (
        .clk   (clk),
        .we    (f_wr.we),
        .waddr (f_wr.addr),
        .wdata (f_wr.start),
        .raddr (f_raddr),
        .rdata (f_rstart)
    );

    bfpa_ram #(.WIDTH(ADDR_W), .DEPTH(FREE_N)) u_free_len (
        .clk   (clk),
        .we    (f_wr.we),
        .waddr (f_wr.addr),
        .wdata (f_wr.len),
        .raddr (f_raddr),
        .rdata (f_rlen)
    );

    bfpa_ram #(.WIDTH(ADDR_W), .DEPTH(USED_N)) u_used_start (
        .clk   (clk),
        .we    (u_wr.we),
        .waddr (u_wr.addr),
        .wdata (u_wr.start),
        .raddr (u_raddr),
        .rdata (u_rstart)
    );

    bfpa_ram #(.WIDTH(ADDR_W), .DEPTH(USED_N)) u_used_len (
        .clk   (clk),
        .we    (u_wr.we),
        .waddr (u_wr.addr),
        .wdata (u_wr.len),
        .raddr (u_raddr),
        .rdata (u_rlen)
    );

endmodule
